// ----- sv/mmpd_pkg.sv -----
`timescale 1ns / 1ps

package mmpd_pkg;

  // Sizes
  localparam int unsigned MAX_COLUMNS = 4096;
  localparam int unsigned ColW        = 12;
  localparam int unsigned CountW      = 13;
  localparam int unsigned WordW       = 32;
  localparam int unsigned StepW       = 32;
  localparam int unsigned BoundW      = 48;
  localparam int unsigned CfgIdxW     = 2;

  // Sample format codes
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_F32 = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_FORMAT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STEP   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COUNT  = 2'd2;

  // Reset values of the registers
  localparam logic [1:0]        FORMAT_RST = FMT_S16;
  localparam logic [StepW-1:0]  STEP_RST   = 32'h0001_0000;
  localparam logic [CountW-1:0] COUNT_RST  = 13'd1024;

  // Smallest legal step: one sample
  localparam logic [StepW-1:0]  STEP_MIN   = 32'h0001_0000;

  // Map the unused code onto signed 16-bit
  function automatic logic [1:0] fmt_eff(input logic [1:0] fmt);
    fmt_eff = (fmt == FMT_U8 || fmt == FMT_F32) ? fmt : FMT_S16;
  endfunction

  function automatic logic [StepW-1:0] step_eff(input logic [StepW-1:0] step);
    step_eff = (step < STEP_MIN) ? STEP_MIN : step;
  endfunction

  function automatic logic [CountW-1:0] count_eff(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] c;
    c = cnt;
    if (c == '0) c = CountW'(1);
    if (c > CountW'(MAX_COLUMNS)) c = CountW'(MAX_COLUMNS);
    count_eff = c;
  endfunction

  // Keep only the bits the format uses
  function automatic logic [WordW-1:0] used_bits(input logic [1:0] fmt,
                                                 input logic [WordW-1:0] w);
    case (fmt)
      FMT_U8:  used_bits = {24'd0, w[7:0]};
      FMT_F32: used_bits = w;
      default: used_bits = {16'd0, w[15:0]};
    endcase
  endfunction

  // Lowest value of the format, start of the running maximum
  function automatic logic [WordW-1:0] peak_max_init(input logic [1:0] fmt);
    case (fmt)
      FMT_U8:  peak_max_init = 32'h0000_0000;
      FMT_F32: peak_max_init = 32'hFF80_0000;
      default: peak_max_init = 32'h0000_8000;
    endcase
  endfunction

  // Highest value of the format, start of the running minimum
  function automatic logic [WordW-1:0] peak_min_init(input logic [1:0] fmt);
    case (fmt)
      FMT_U8:  peak_min_init = 32'h0000_00FF;
      FMT_F32: peak_min_init = 32'h7F80_0000;
      default: peak_min_init = 32'h0000_7FFF;
    endcase
  endfunction

  // Key that orders words as unsigned integers in the value order of the format
  function automatic logic [WordW-1:0] order_key(input logic [1:0] fmt,
                                                 input logic [WordW-1:0] w);
    logic [WordW-1:0] v;
    v = (w == 32'h8000_0000) ? '0 : w;
    case (fmt)
      FMT_U8:  order_key = {24'd0, w[7:0]};
      FMT_F32: order_key = v[31] ? ~v : (v | 32'h8000_0000);
      default: order_key = {16'd0, w[15:0] ^ 16'h8000};
    endcase
  endfunction

endpackage

// ----- sv/mmpd_if.sv -----
`timescale 1ns / 1ps

// Sample stream word
interface mmpd_sample_if;
  logic                             valid;
  logic                             ready;
  logic [mmpd_pkg::WordW-1:0]       sample_word;
  logic                             last_sample;

  modport source (output valid, output sample_word, output last_sample, input ready);
  modport sink   (input valid, input sample_word, input last_sample, output ready);
endinterface

// Column result word
interface mmpd_column_if;
  logic                             valid;
  logic                             ready;
  logic [mmpd_pkg::ColW-1:0]        column;
  logic [mmpd_pkg::WordW-1:0]       peak_high;
  logic [mmpd_pkg::WordW-1:0]       peak_low;
  logic                             final_column;

  modport source (output valid, output column, output peak_high, output peak_low,
                  output final_column, input ready);
  modport sink   (input valid, input column, input peak_high, input peak_low,
                  input final_column, output ready);
endinterface

// Register write word
interface mmpd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mmpd_pkg::CfgIdxW-1:0]     index;
  logic [mmpd_pkg::WordW-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mmpd_peak.sv -----
`timescale 1ns / 1ps

// Compare one sample against the running extremes in the order of the format.
module mmpd_peak (
  input  logic [1:0]                 fmt_i,
  input  logic [mmpd_pkg::WordW-1:0] word_i,
  input  logic [mmpd_pkg::WordW-1:0] run_max_i,
  input  logic [mmpd_pkg::WordW-1:0] run_min_i,
  output logic [mmpd_pkg::WordW-1:0] max_o,
  output logic [mmpd_pkg::WordW-1:0] min_o
);

  logic                       is_nan;
  logic [mmpd_pkg::WordW-1:0] key;
  logic [mmpd_pkg::WordW-1:0] key_max;
  logic [mmpd_pkg::WordW-1:0] key_min;

  assign is_nan  = (fmt_i == mmpd_pkg::FMT_F32) &&
                   (word_i[30:23] == 8'hFF) && (word_i[22:0] != '0);
  assign key     = mmpd_pkg::order_key(fmt_i, word_i);
  assign key_max = mmpd_pkg::order_key(fmt_i, run_max_i);
  assign key_min = mmpd_pkg::order_key(fmt_i, run_min_i);

  // Replace only on a strict win; drop NaNs
  assign max_o = (!is_nan && key > key_max) ? word_i : run_max_i;
  assign min_o = (!is_nan && key < key_min) ? word_i : run_min_i;

endmodule

// ----- sv/min_max_peak_decimator.sv -----
`timescale 1ns / 1ps

// Min/max peak decimator for waveform display.
// sample_ch takes one raw sample word per cycle while ready is high (u8, s16
// or float32 bits, with a last_sample flag). column_ch returns one word per
// closed display column: its index, the greatest and least used sample bits
// in the format's order, and final_column. cfg_ch writes sample_format (0),
// bin_step (1, 16.16) and column_count (2); a write to one of these restarts
// the column count from zero, a write to the spare index does nothing. Write
// only while idle. Throughput: one sample per cycle while the receiver takes
// each result. A sample accepted into the input register is compared there;
// its column word then enters the result register for the receiver.
// The result register parts the two sides: while a result waits, one more
// sample is taken into the input register; that sample then holds until the
// receiver takes the result. sample_ch.ready falls only in that case.
// After the final column, samples are accepted and dropped until a write to
// a known register or reset. Reset (rst_ni low, asynchronous) loads format
// s16, step 1.0, 1024 columns, and clears both pipeline valid flags.
module min_max_peak_decimator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mmpd_sample_if.sink          sample_ch,
  mmpd_column_if.source        column_ch,
  mmpd_cfg_if.sink             cfg_ch
);

  // Configuration registers
  logic [1:0]                      fmt_q, fmt_d;
  logic [mmpd_pkg::StepW-1:0]      step_q, step_d;
  logic [mmpd_pkg::CountW-1:0]     count_q, count_d;

  // Column state
  logic [31:0]                     smp_cnt_q, smp_cnt_d;
  logic [mmpd_pkg::BoundW-1:0]     bound_q, bound_d;
  logic [mmpd_pkg::ColW-1:0]       col_q, col_d;
  logic [mmpd_pkg::WordW-1:0]      run_max_q, run_max_d;
  logic [mmpd_pkg::WordW-1:0]      run_min_q, run_min_d;
  logic                            finished_q, finished_d;

  // Input register
  logic                            s1_valid_q;
  logic [mmpd_pkg::WordW-1:0]      s1_word_q;
  logic                            s1_last_q;

  // Result register
  logic                            out_valid_q;
  logic [mmpd_pkg::ColW-1:0]       out_col_q;
  logic [mmpd_pkg::WordW-1:0]      out_high_q;
  logic [mmpd_pkg::WordW-1:0]      out_low_q;
  logic                            out_final_q;

  logic                            cfg_wr;
  logic                            s1_go;
  logic                            s1_fire;
  logic                            in_fire;
  logic [1:0]                      fmt_e, fmt_n;
  logic [mmpd_pkg::StepW-1:0]      step_e, step_n;
  logic [mmpd_pkg::CountW-1:0]     count_e;
  logic [mmpd_pkg::WordW-1:0]      word_u;
  logic [mmpd_pkg::WordW-1:0]      pk_max, pk_min;
  logic [31:0]                     cnt_inc;
  logic                            close;
  logic                            last_col;
  logic                            is_final;
  logic                            emit;

  assign cfg_wr  = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Advance the input register when the result register is free or drains
  assign s1_go   = !out_valid_q || column_ch.ready;
  assign s1_fire = s1_valid_q && s1_go;
  assign sample_ch.ready = !s1_valid_q || s1_go;
  assign in_fire = sample_ch.valid && sample_ch.ready;

  assign fmt_e   = mmpd_pkg::fmt_eff(fmt_q);
  assign step_e  = mmpd_pkg::step_eff(step_q);
  assign count_e = mmpd_pkg::count_eff(count_q);
  assign word_u  = mmpd_pkg::used_bits(fmt_e, s1_word_q);

  mmpd_peak u_peak (
    .fmt_i     (fmt_e),
    .word_i    (word_u),
    .run_max_i (run_max_q),
    .run_min_i (run_min_q),
    .max_o     (pk_max),
    .min_o     (pk_min)
  );

  // Column boundary and stop decision
  assign cnt_inc  = smp_cnt_q + 32'd1;
  assign close    = cnt_inc >= bound_q[mmpd_pkg::BoundW-1:16];
  assign last_col = ({1'b0, col_q} + mmpd_pkg::CountW'(1)) >= count_e;
  assign is_final = s1_last_q || (close && last_col);
  assign emit     = s1_fire && !finished_q && (close || is_final);

  // Next configuration and column state
  always_comb begin
    fmt_d      = fmt_q;
    step_d     = step_q;
    count_d    = count_q;
    smp_cnt_d  = smp_cnt_q;
    bound_d    = bound_q;
    col_d      = col_q;
    run_max_d  = run_max_q;
    run_min_d  = run_min_q;
    finished_d = finished_q;
    fmt_n      = fmt_e;
    step_n     = step_e;
    if (cfg_wr) begin
      case (cfg_ch.index)
        mmpd_pkg::REG_FORMAT: fmt_d   = cfg_ch.data[1:0];
        mmpd_pkg::REG_STEP:   step_d  = cfg_ch.data;
        mmpd_pkg::REG_COUNT:  count_d = cfg_ch.data[mmpd_pkg::CountW-1:0];
        default: ;
      endcase
      // Restart from the new settings on a write to a known register
      if (cfg_ch.index == mmpd_pkg::REG_FORMAT || cfg_ch.index == mmpd_pkg::REG_STEP ||
          cfg_ch.index == mmpd_pkg::REG_COUNT) begin
        fmt_n      = mmpd_pkg::fmt_eff(fmt_d);
        step_n     = mmpd_pkg::step_eff(step_d);
        smp_cnt_d  = '0;
        bound_d    = {16'd0, step_n};
        col_d      = '0;
        finished_d = 1'b0;
        run_max_d  = mmpd_pkg::peak_max_init(fmt_n);
        run_min_d  = mmpd_pkg::peak_min_init(fmt_n);
      end
    end else if (s1_fire && !finished_q) begin
      smp_cnt_d = cnt_inc;
      run_max_d = pk_max;
      run_min_d = pk_min;
      if (is_final) begin
        finished_d = 1'b1;
      end else if (close) begin
        col_d     = col_q + mmpd_pkg::ColW'(1);
        bound_d   = bound_q + {16'd0, step_e};
        run_max_d = mmpd_pkg::peak_max_init(fmt_e);
        run_min_d = mmpd_pkg::peak_min_init(fmt_e);
      end
    end
  end

  // Hold configuration and column state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q      <= mmpd_pkg::FORMAT_RST;
      step_q     <= mmpd_pkg::STEP_RST;
      count_q    <= mmpd_pkg::COUNT_RST;
      smp_cnt_q  <= '0;
      bound_q    <= {16'd0, mmpd_pkg::STEP_RST};
      col_q      <= '0;
      run_max_q  <= mmpd_pkg::peak_max_init(mmpd_pkg::FORMAT_RST);
      run_min_q  <= mmpd_pkg::peak_min_init(mmpd_pkg::FORMAT_RST);
      finished_q <= 1'b0;
    end else begin
      fmt_q      <= fmt_d;
      step_q     <= step_d;
      count_q    <= count_d;
      smp_cnt_q  <= smp_cnt_d;
      bound_q    <= bound_d;
      col_q      <= col_d;
      run_max_q  <= run_max_d;
      run_min_q  <= run_min_d;
      finished_q <= finished_d;
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_ch.ready) begin
      s1_valid_q <= sample_ch.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= sample_ch.sample_word;
      s1_last_q <= sample_ch.last_sample;
    end
  end

  // Result register valid: load on a closed column, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= emit;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_col_q   <= col_q;
      out_high_q  <= pk_max;
      out_low_q   <= pk_min;
      out_final_q <= is_final;
    end
  end

  assign column_ch.valid        = out_valid_q;
  assign column_ch.column       = out_col_q;
  assign column_ch.peak_high    = out_high_q;
  assign column_ch.peak_low     = out_low_q;
  assign column_ch.final_column = out_final_q;

  // A final column stops the stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && is_final && !cfg_wr |=> finished_q)
    else $error("final column did not stop the stream");

  // No result once stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q && !cfg_wr |-> !emit)
    else $error("result produced after the final column");

  // Emitted column index stays below the effective column count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, out_col_q} < count_e))
    else $error("column index beyond column count");

  // A register write restarts the stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (cfg_ch.index == mmpd_pkg::REG_FORMAT || cfg_ch.index == mmpd_pkg::REG_STEP ||
               cfg_ch.index == mmpd_pkg::REG_COUNT)
    |=> (smp_cnt_q == '0) && (col_q == '0) && !finished_q)
    else $error("register write did not restart the stream");

endmodule
